// ----- hdl/normalized_vector_lerp_defines.svh -----
// ----------------------------------------------------------------------------
// normalized_vector_lerp assertion macros
// Shared property forms for the nlerp block checks.
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_VECTOR_LERP_DEFINES_SVH
`define NORMALIZED_VECTOR_LERP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define NLERP_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nlerp check failed");

// next-cycle implication, disabled in reset
`define NLERP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nlerp check failed");

`endif

// ----- hdl/nlerp_pkg.sv -----
// ----------------------------------------------------------------------------
// nlerp_pkg
// Widths, constants and sideband types of the nlerp pipeline.
// ----------------------------------------------------------------------------
package nlerp_pkg;

    localparam int W_COMP     = 16;   // input vector component
    localparam int W_BLEND    = 17;   // Q0.16 weight
    localparam int W_SQ       = 32;   // squared length of an input vector
    localparam int W_RAD      = 60;   // square root radicand
    localparam int W_LEN      = 30;   // square root result
    localparam int W_UNIT_NUM = 50;   // |c| * 2^34 + len / 2
    localparam int W_UNIT_Q   = 22;   // unit component magnitude, Q.20
    localparam int W_PROD     = 41;   // weight times unit component
    localparam int W_BMAG     = 21;   // blend component magnitude
    localparam int W_BSQ      = 42;   // squared blend length
    localparam int W_OUT_NUM  = 44;   // |b| * 2^23 + len / 2
    localparam int W_OUT_Q    = 16;   // output magnitude, Q1.14

    localparam logic [W_BLEND-1:0] ONE_Q16 = 17'd65536;
    localparam logic [W_OUT_Q-1:0] U_MAX   = 16'd16384;

    // input squares through the first root
    typedef struct packed {
        logic [5:0]             neg;
        logic [5:0][W_COMP-1:0] mag;
        logic [W_BLEND-1:0]     blend;
        logic [W_BLEND-1:0]     blend_c;
        logic                   deg;
    } t_side_len;

    // through the unit division
    typedef struct packed {
        logic [5:0]         neg;
        logic [W_BLEND-1:0] blend;
        logic [W_BLEND-1:0] blend_c;
        logic               deg;
    } t_side_unit;

    // blend components through the second root
    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][W_BMAG-1:0] mag;
        logic                   deg;
    } t_side_norm;

    // through the output division
    typedef struct packed {
        logic [2:0] neg;
        logic       deg;
    } t_side_out;

endpackage

// ----- hdl/nlerp_sqrt.sv -----
// ----------------------------------------------------------------------------
// nlerp_sqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module nlerp_sqrt #(
    parameter int LANES  = 2,
    parameter int W_RAD  = nlerp_pkg::W_RAD,
    parameter int W_SIDE = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [LANES-1:0][W_RAD-1:0]         i_rad,
    input  logic [W_SIDE-1:0]                   i_side,
    output logic                                o_valid,
    output logic [LANES-1:0][W_RAD/2-1:0]       o_root,
    output logic [W_SIDE-1:0]                   o_side
);

    localparam int W_ROOT = W_RAD / 2;
    localparam int W_REM  = W_ROOT + 3;

    logic [W_ROOT-1:0]                r_vld;
    logic [LANES-1:0][W_RAD-1:0]      r_rad  [W_ROOT];
    logic [LANES-1:0][W_REM-1:0]      r_rem  [W_ROOT];
    logic [LANES-1:0][W_ROOT-1:0]     r_root [W_ROOT];
    logic [W_SIDE-1:0]                r_side [W_ROOT];

    logic [LANES-1:0][W_RAD-1:0]      s_rad  [W_ROOT];
    logic [LANES-1:0][W_REM-1:0]      s_rem  [W_ROOT];
    logic [LANES-1:0][W_ROOT-1:0]     s_root [W_ROOT];
    logic [LANES-1:0][W_REM-1:0]      s_cur  [W_ROOT];
    logic [LANES-1:0][W_REM-1:0]      s_try  [W_ROOT];
    logic [LANES-1:0][W_RAD-1:0]      n_rad  [W_ROOT];
    logic [LANES-1:0][W_REM-1:0]      n_rem  [W_ROOT];
    logic [LANES-1:0][W_ROOT-1:0]     n_root [W_ROOT];

    // one restoring root step per stage: bring down two radicand bits
    always_comb begin
        for (int k = 0; k < W_ROOT; k++) begin
            if (k == 0) begin
                s_rad[k]  = i_rad;
                s_rem[k]  = '0;
                s_root[k] = '0;
            end else begin
                s_rad[k]  = r_rad[k-1];
                s_rem[k]  = r_rem[k-1];
                s_root[k] = r_root[k-1];
            end
            for (int l = 0; l < LANES; l++) begin
                s_cur[k][l] = {s_rem[k][l][W_REM-3:0], s_rad[k][l][W_RAD-1 -: 2]};
                s_try[k][l] = {1'b0, s_root[k][l], 2'b01};
                n_rad[k][l] = s_rad[k][l] << 2;
                if (s_cur[k][l] >= s_try[k][l]) begin
                    n_rem[k][l]  = s_cur[k][l] - s_try[k][l];
                    n_root[k][l] = {s_root[k][l][W_ROOT-2:0], 1'b1};
                end else begin
                    n_rem[k][l]  = s_cur[k][l];
                    n_root[k][l] = {s_root[k][l][W_ROOT-2:0], 1'b0};
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W_ROOT-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W_ROOT; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[W_ROOT-1];
    assign o_root  = r_root[W_ROOT-1];
    assign o_side  = r_side[W_ROOT-1];

endmodule

// ----- hdl/nlerp_div.sv -----
// ----------------------------------------------------------------------------
// nlerp_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module nlerp_div #(
    parameter int LANES  = 3,
    parameter int W_NUM  = nlerp_pkg::W_OUT_NUM,
    parameter int W_DEN  = nlerp_pkg::W_LEN,
    parameter int W_QUO  = nlerp_pkg::W_OUT_Q,
    parameter int W_SIDE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [LANES-1:0][W_NUM-1:0]   i_num,
    input  logic [LANES-1:0][W_DEN-1:0]   i_den,
    input  logic [W_SIDE-1:0]             i_side,
    output logic                          o_valid,
    output logic [LANES-1:0][W_QUO-1:0]   o_quo,
    output logic [W_SIDE-1:0]             o_side
);

    // quotient must fit W_QUO bits, so the top numerator bits stay below den
    logic [W_QUO-1:0]                 r_vld;
    logic [LANES-1:0][W_DEN-1:0]      r_rem [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      r_low [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      r_quo [W_QUO];
    logic [LANES-1:0][W_DEN-1:0]      r_den [W_QUO];
    logic [W_SIDE-1:0]                r_side [W_QUO];

    logic [LANES-1:0][W_DEN-1:0]      s_rem [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      s_low [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      s_quo [W_QUO];
    logic [LANES-1:0][W_DEN-1:0]      s_den [W_QUO];
    logic [LANES-1:0][W_DEN:0]        s_cur [W_QUO];
    logic [LANES-1:0][W_DEN-1:0]      n_rem [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      n_low [W_QUO];
    logic [LANES-1:0][W_QUO-1:0]      n_quo [W_QUO];

    // one compare and subtract per stage
    always_comb begin
        for (int k = 0; k < W_QUO; k++) begin
            for (int l = 0; l < LANES; l++) begin
                if (k == 0) begin
                    s_rem[k][l] = W_DEN'(i_num[l][W_NUM-1:W_QUO]);
                    s_low[k][l] = i_num[l][W_QUO-1:0];
                    s_quo[k][l] = '0;
                    s_den[k][l] = i_den[l];
                end else begin
                    s_rem[k][l] = r_rem[k-1][l];
                    s_low[k][l] = r_low[k-1][l];
                    s_quo[k][l] = r_quo[k-1][l];
                    s_den[k][l] = r_den[k-1][l];
                end
                s_cur[k][l] = {s_rem[k][l], s_low[k][l][W_QUO-1]};
                n_low[k][l] = s_low[k][l] << 1;
                if (s_cur[k][l] >= {1'b0, s_den[k][l]}) begin
                    n_rem[k][l] = W_DEN'(s_cur[k][l] - {1'b0, s_den[k][l]});
                    n_quo[k][l] = {s_quo[k][l][W_QUO-2:0], 1'b1};
                end else begin
                    n_rem[k][l] = s_cur[k][l][W_DEN-1:0];
                    n_quo[k][l] = {s_quo[k][l][W_QUO-2:0], 1'b0};
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[W_QUO-2:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W_QUO; k++) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= s_den[k];
                r_side[k] <= (k == 0) ? i_side : r_side[k-1];
            end
        end
    end

    assign o_valid = r_vld[W_QUO-1];
    assign o_quo   = r_quo[W_QUO-1];
    assign o_side  = r_side[W_QUO-1];

endmodule

// ----- hdl/normalized_vector_lerp.sv -----
// ----------------------------------------------------------------------------
// normalized_vector_lerp
// Normalized linear interpolation of two 3-D vectors, unit result in Q1.14.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while o_stall is low and returns the results in order:
// three input stages (magnitude, squares, sums), a 30-stage bit-per-stage
// square root for both input lengths, a 22-stage divider for the six unit
// components, five blend stages (weight multiply, add, round, square, sum),
// a second 30-stage root, a 16-stage output divider and the output register.
// The pipeline holds as a whole while a result waits under i_stall; o_stall
// follows i_stall only while the output register is full. A zero-length
// input or blend gives zero components with o_degenerate set.
module normalized_vector_lerp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_v_x,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_v_y,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_v_z,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_w_x,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_w_y,
    input  logic signed [nlerp_pkg::W_COMP-1:0]   i_w_z,
    input  logic        [nlerp_pkg::W_BLEND-1:0]  i_blend,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [nlerp_pkg::W_OUT_Q-1:0]  o_u_x,
    output logic signed [nlerp_pkg::W_OUT_Q-1:0]  o_u_y,
    output logic signed [nlerp_pkg::W_OUT_Q-1:0]  o_u_z,
    output logic                                  o_degenerate
);

`include "normalized_vector_lerp_defines.svh"

    localparam int W_COMP  = nlerp_pkg::W_COMP;
    localparam int W_BLEND = nlerp_pkg::W_BLEND;
    localparam int W_SQ    = nlerp_pkg::W_SQ;
    localparam int W_LEN   = nlerp_pkg::W_LEN;
    localparam int W_UQ    = nlerp_pkg::W_UNIT_Q;
    localparam int W_UNUM  = nlerp_pkg::W_UNIT_NUM;
    localparam int W_PROD  = nlerp_pkg::W_PROD;
    localparam int W_BMAG  = nlerp_pkg::W_BMAG;
    localparam int W_BSQ   = nlerp_pkg::W_BSQ;
    localparam int W_ONUM  = nlerp_pkg::W_OUT_NUM;
    localparam int W_OQ    = nlerp_pkg::W_OUT_Q;

    logic w_en;

    logic signed [W_COMP-1:0] w_comp [6];

    logic                         r_s1_vld;
    nlerp_pkg::t_side_len         r_s1_side;
    nlerp_pkg::t_side_len         n_s1_side;
    logic                         r_s2_vld;
    nlerp_pkg::t_side_len         r_s2_side;
    logic [5:0][W_SQ-1:0]         r_s2_sq;
    logic                         r_s3_vld;
    nlerp_pkg::t_side_len         r_s3_side;
    nlerp_pkg::t_side_len         n_s3_side;
    logic [1:0][W_SQ-1:0]         r_s3_s;
    logic [W_SQ+1:0]              w_sum_v;
    logic [W_SQ+1:0]              w_sum_w;

    logic [1:0][nlerp_pkg::W_RAD-1:0]  w_rad1;
    logic                              w_r1_vld;
    logic [1:0][W_LEN-1:0]             w_len1;
    logic [$bits(nlerp_pkg::t_side_len)-1:0] w_r1_side_bits;
    nlerp_pkg::t_side_len              w_r1_side;

    logic [5:0][W_UNUM-1:0]            w_unum;
    logic [5:0][W_LEN-1:0]             w_uden;
    nlerp_pkg::t_side_unit             w_d1_side_in;
    logic                              w_d1_vld;
    logic [5:0][W_UQ-1:0]              w_unit;
    logic [$bits(nlerp_pkg::t_side_unit)-1:0] w_d1_side_bits;
    nlerp_pkg::t_side_unit             w_d1_side;

    logic signed [W_UQ:0]              w_nunit [6];
    logic                              r_m1_vld;
    logic                              r_m1_deg;
    logic signed [W_PROD-1:0]          r_m1_prod [6];
    logic                              r_m2_vld;
    logic                              r_m2_deg;
    logic signed [W_PROD-1:0]          r_m2_acc [3];
    logic [W_PROD-1:0]                 w_acc_mag [3];
    logic [W_PROD-1:0]                 w_acc_rnd [3];
    logic                              r_m3_vld;
    nlerp_pkg::t_side_norm             r_m3_side;
    nlerp_pkg::t_side_norm             n_m3_side;
    logic                              r_m4_vld;
    nlerp_pkg::t_side_norm             r_m4_side;
    logic [2:0][W_BSQ-1:0]             r_m4_sq;
    logic [W_BSQ+1:0]                  w_bsum;
    logic                              r_m5_vld;
    nlerp_pkg::t_side_norm             r_m5_side;
    nlerp_pkg::t_side_norm             n_m5_side;
    logic [W_BSQ-1:0]                  r_m5_s;

    logic [0:0][nlerp_pkg::W_RAD-1:0]  w_rad2;
    logic                              w_r2_vld;
    logic [0:0][W_LEN-1:0]             w_len2;
    logic [$bits(nlerp_pkg::t_side_norm)-1:0] w_r2_side_bits;
    nlerp_pkg::t_side_norm             w_r2_side;

    logic [2:0][W_ONUM-1:0]            w_onum;
    logic [2:0][W_LEN-1:0]             w_oden;
    nlerp_pkg::t_side_out              w_d2_side_in;
    logic                              w_d2_vld;
    logic [2:0][W_OQ-1:0]              w_oquo;
    logic [$bits(nlerp_pkg::t_side_out)-1:0] w_d2_side_bits;
    nlerp_pkg::t_side_out              w_d2_side;

    logic [W_OQ-1:0]                   w_omag [3];
    logic signed [W_OQ-1:0]            w_ocomp [3];

    logic                              r_out_vld;
    logic signed [W_OQ-1:0]            r_u_x;
    logic signed [W_OQ-1:0]            r_u_y;
    logic signed [W_OQ-1:0]            r_u_z;
    logic                              r_deg;
    logic                              w_in_range;

    // whole pipeline advances unless a result waits under stall
    assign w_en    = !r_out_vld || !i_stall;
    assign o_stall = !w_en;

    assign w_comp[0] = i_v_x;
    assign w_comp[1] = i_v_y;
    assign w_comp[2] = i_v_z;
    assign w_comp[3] = i_w_x;
    assign w_comp[4] = i_w_y;
    assign w_comp[5] = i_w_z;

    // stage 1: component magnitudes, weight saturation
    always_comb begin
        n_s1_side = '0;
        for (int i = 0; i < 6; i++) begin
            n_s1_side.neg[i] = w_comp[i][W_COMP-1];
            n_s1_side.mag[i] = w_comp[i][W_COMP-1] ? (~w_comp[i] + 1'b1) : w_comp[i];
        end
        n_s1_side.blend   = (i_blend > nlerp_pkg::ONE_Q16) ? nlerp_pkg::ONE_Q16 : i_blend;
        n_s1_side.blend_c = nlerp_pkg::ONE_Q16 - n_s1_side.blend;
        n_s1_side.deg     = 1'b0;
    end

    // stage 3 sums of squares
    assign w_sum_v = (W_SQ+2)'(r_s2_sq[0]) + (W_SQ+2)'(r_s2_sq[1]) + (W_SQ+2)'(r_s2_sq[2]);
    assign w_sum_w = (W_SQ+2)'(r_s2_sq[3]) + (W_SQ+2)'(r_s2_sq[4]) + (W_SQ+2)'(r_s2_sq[5]);

    // stage 3 sideband with zero-length flag
    always_comb begin
        n_s3_side     = r_s2_side;
        n_s3_side.deg = (w_sum_v == '0) || (w_sum_w == '0);
    end

    // input stages: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // input stages: payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_side <= n_s1_side;
            r_s2_side <= r_s1_side;
            for (int i = 0; i < 6; i++) begin
                r_s2_sq[i] <= r_s1_side.mag[i] * r_s1_side.mag[i];
            end
            r_s3_side     <= n_s3_side;
            r_s3_s[0]     <= w_sum_v[W_SQ-1:0];
            r_s3_s[1]     <= w_sum_w[W_SQ-1:0];
        end
    end

    // input lengths in Q.14
    assign w_rad1[0] = {r_s3_s[0], (nlerp_pkg::W_RAD - W_SQ)'(0)};
    assign w_rad1[1] = {r_s3_s[1], (nlerp_pkg::W_RAD - W_SQ)'(0)};

    nlerp_sqrt #(
        .LANES  (2),
        .W_RAD  (nlerp_pkg::W_RAD),
        .W_SIDE ($bits(nlerp_pkg::t_side_len))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s3_vld),
        .i_rad   (w_rad1),
        .i_side  (r_s3_side),
        .o_valid (w_r1_vld),
        .o_root  (w_len1),
        .o_side  (w_r1_side_bits)
    );

    assign w_r1_side = w_r1_side_bits;

    // unit numerators: |c| * 2^34 plus half the length for rounding
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_uden[i] = (i < 3) ? w_len1[0] : w_len1[1];
            w_unum[i] = {w_r1_side.mag[i], (W_UNUM - W_COMP)'(0)}
                      + W_UNUM'(w_uden[i] >> 1);
        end
        w_d1_side_in.neg     = w_r1_side.neg;
        w_d1_side_in.blend   = w_r1_side.blend;
        w_d1_side_in.blend_c = w_r1_side.blend_c;
        w_d1_side_in.deg     = w_r1_side.deg;
    end

    nlerp_div #(
        .LANES  (6),
        .W_NUM  (W_UNUM),
        .W_DEN  (W_LEN),
        .W_QUO  (W_UQ),
        .W_SIDE ($bits(nlerp_pkg::t_side_unit))
    ) u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r1_vld),
        .i_num   (w_unum),
        .i_den   (w_uden),
        .i_side  (w_d1_side_in),
        .o_valid (w_d1_vld),
        .o_quo   (w_unit),
        .o_side  (w_d1_side_bits)
    );

    assign w_d1_side = w_d1_side_bits;

    // signed unit components in Q.20
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_nunit[i] = w_d1_side.neg[i] ? -$signed({1'b0, w_unit[i]})
                                          : $signed({1'b0, w_unit[i]});
        end
    end

    // blend rounding: magnitude plus half, drop 16 bits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_acc_mag[i] = r_m2_acc[i][W_PROD-1] ? W_PROD'(-r_m2_acc[i]) : r_m2_acc[i];
            w_acc_rnd[i] = w_acc_mag[i] + W_PROD'(32768);
        end
        n_m3_side.deg = r_m2_deg;
        for (int i = 0; i < 3; i++) begin
            n_m3_side.neg[i] = r_m2_acc[i][W_PROD-1];
            n_m3_side.mag[i] = w_acc_rnd[i][W_BMAG+15:16];
        end
    end

    // squared blend length
    assign w_bsum = (W_BSQ+2)'(r_m4_sq[0]) + (W_BSQ+2)'(r_m4_sq[1]) + (W_BSQ+2)'(r_m4_sq[2]);

    // stage 5 sideband with zero-blend flag
    always_comb begin
        n_m5_side     = r_m4_side;
        n_m5_side.deg = r_m4_side.deg || (w_bsum == '0);
    end

    // blend stages: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
            r_m5_vld <= 1'b0;
        end else if (w_en) begin
            r_m1_vld <= w_d1_vld;
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            r_m4_vld <= r_m3_vld;
            r_m5_vld <= r_m4_vld;
        end
    end

    // blend stages: payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m1_deg <= w_d1_side.deg;
            for (int i = 0; i < 3; i++) begin
                r_m1_prod[i]   <= $signed({1'b0, w_d1_side.blend_c}) * w_nunit[i];
                r_m1_prod[i+3] <= $signed({1'b0, w_d1_side.blend}) * w_nunit[i+3];
                r_m2_acc[i]    <= r_m1_prod[i] + r_m1_prod[i+3];
                r_m4_sq[i]     <= r_m3_side.mag[i] * r_m3_side.mag[i];
            end
            r_m2_deg      <= r_m1_deg;
            r_m3_side     <= n_m3_side;
            r_m4_side     <= r_m3_side;
            r_m5_side     <= n_m5_side;
            r_m5_s        <= w_bsum[W_BSQ-1:0];
        end
    end

    // blend length in Q.9
    assign w_rad2[0] = {r_m5_s, (nlerp_pkg::W_RAD - W_BSQ)'(0)};

    nlerp_sqrt #(
        .LANES  (1),
        .W_RAD  (nlerp_pkg::W_RAD),
        .W_SIDE ($bits(nlerp_pkg::t_side_norm))
    ) u_blend_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m5_vld),
        .i_rad   (w_rad2),
        .i_side  (r_m5_side),
        .o_valid (w_r2_vld),
        .o_root  (w_len2),
        .o_side  (w_r2_side_bits)
    );

    assign w_r2_side = w_r2_side_bits;

    // output numerators: |b| * 2^23 plus half the length
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_oden[i] = w_len2[0];
            w_onum[i] = {w_r2_side.mag[i], (W_ONUM - W_BMAG)'(0)}
                      + W_ONUM'(w_len2[0] >> 1);
        end
        w_d2_side_in.neg = w_r2_side.neg;
        w_d2_side_in.deg = w_r2_side.deg;
    end

    nlerp_div #(
        .LANES  (3),
        .W_NUM  (W_ONUM),
        .W_DEN  (W_LEN),
        .W_QUO  (W_OQ),
        .W_SIDE ($bits(nlerp_pkg::t_side_out))
    ) u_out_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_r2_vld),
        .i_num   (w_onum),
        .i_den   (w_oden),
        .i_side  (w_d2_side_in),
        .o_valid (w_d2_vld),
        .o_quo   (w_oquo),
        .o_side  (w_d2_side_bits)
    );

    assign w_d2_side = w_d2_side_bits;

    // clamp, apply sign, zero on degenerate
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_omag[i] = (w_oquo[i] > nlerp_pkg::U_MAX) ? nlerp_pkg::U_MAX : w_oquo[i];
            if (w_d2_side.deg) begin
                w_ocomp[i] = '0;
            end else if (w_d2_side.neg[i]) begin
                w_ocomp[i] = -$signed(w_omag[i]);
            end else begin
                w_ocomp[i] = $signed(w_omag[i]);
            end
        end
    end

    // output register: valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d2_vld;
        end
    end

    // output register: payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u_x <= w_ocomp[0];
            r_u_y <= w_ocomp[1];
            r_u_z <= w_ocomp[2];
            r_deg <= w_d2_side.deg;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_u_x        = r_u_x;
    assign o_u_y        = r_u_y;
    assign o_u_z        = r_u_z;
    assign o_degenerate = r_deg;

    // unit components stay within one in Q1.14
    assign w_in_range = (r_u_x <= 16'sd16384) && (r_u_x >= -16'sd16384)
                     && (r_u_y <= 16'sd16384) && (r_u_y >= -16'sd16384)
                     && (r_u_z <= 16'sd16384) && (r_u_z >= -16'sd16384);

    // checks
    `NLERP_ASSERT(a_deg_zero, i_clk, i_rst_n, r_out_vld && r_deg, (r_u_x == '0) && (r_u_y == '0) && (r_u_z == '0))
    `NLERP_ASSERT(a_unit_range, i_clk, i_rst_n, r_out_vld, w_in_range)
    `NLERP_ASSERT(a_stall_cause, i_clk, i_rst_n, o_stall, r_out_vld && i_stall)
    `NLERP_ASSERT_NEXT(a_pipe_hold, i_clk, i_rst_n, !w_en, $stable(r_s1_vld) && $stable(r_m5_vld))

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nlerp pipeline. Directed and random vector
// pairs are sent through the valid/stall input channel. Each accepted
// transaction is predicted in exact integer arithmetic, and the expected unit
// vector is queued. Every result leaving the block is checked against the
// oldest entry. Both sides idle at random, and the receiver also holds off for
// one long stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int LATENCY     = 107;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic signed [nlerp_pkg::W_COMP-1:0] v [3];
        logic signed [nlerp_pkg::W_COMP-1:0] w [3];
        logic [nlerp_pkg::W_BLEND-1:0]       blend;
    } t_vec_pair;

    typedef struct {
        logic signed [nlerp_pkg::W_OUT_Q-1:0] u [3];
        logic                                 deg;
    } t_unit_vec;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 i_stall = 1'b0;
    logic signed [nlerp_pkg::W_COMP-1:0]  i_v_x = '0, i_v_y = '0, i_v_z = '0;
    logic signed [nlerp_pkg::W_COMP-1:0]  i_w_x = '0, i_w_y = '0, i_w_z = '0;
    logic [nlerp_pkg::W_BLEND-1:0]        i_blend = '0;
    logic                                 o_stall, o_valid, o_degenerate;
    logic signed [nlerp_pkg::W_OUT_Q-1:0] o_u_x, o_u_y, o_u_z;

    t_unit_vec expected_units [$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        long_hold_left = 0;
    int        result_wait = 0;
    bit        idle_enable = 1'b1;

    normalized_vector_lerp uut (.*);

    always #5 i_clk = ~i_clk;

    // exact predictor
    function automatic longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned res = 0;
        longint unsigned bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_scaled_div(longint x, int sh, longint unsigned d);
        longint unsigned m = (x < 0) ? longint'(-x) : longint'(x);
        longint unsigned q = ((m << sh) + d / 2) / d;
        return (x < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_unit_vec predict_nlerp(t_vec_pair p);
        t_unit_vec r;
        longint a, acc, u;
        longint nv [3], nw [3], b [3];
        longint unsigned sv = 0, sw = 0, sb = 0, lv, lw, lb, m;
        a = (p.blend > nlerp_pkg::ONE_Q16) ? 65536 : longint'(p.blend);
        foreach (r.u[i]) r.u[i] = '0;
        r.deg = 1'b1;
        for (int i = 0; i < 3; i++) begin
            sv += longint'(p.v[i]) * longint'(p.v[i]);
            sw += longint'(p.w[i]) * longint'(p.w[i]);
        end
        if (sv == 0 || sw == 0) return r;
        lv = sqrt_floor(sv << 28);
        lw = sqrt_floor(sw << 28);
        for (int i = 0; i < 3; i++) begin
            nv[i] = round_scaled_div(longint'(p.v[i]), 34, lv);
            nw[i] = round_scaled_div(longint'(p.w[i]), 34, lw);
            acc = (65536 - a) * nv[i] + a * nw[i];
            m = (((acc < 0) ? -acc : acc) + 32768) >> 16;
            b[i] = (acc < 0) ? -longint'(m) : longint'(m);
            sb += m * m;
        end
        if (sb == 0) return r;
        lb = sqrt_floor(sb << 18);
        for (int i = 0; i < 3; i++) begin
            u = round_scaled_div(b[i], 23, lb);
            if (u > 16384) u = 16384;
            if (u < -16384) u = -16384;
            r.u[i] = u[nlerp_pkg::W_OUT_Q-1:0];
        end
        r.deg = 1'b0;
        return r;
    endfunction

    // send one transaction, idle gap first
    task automatic send_pair(t_vec_pair p);
        int gap = idle_enable ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_v_x <= p.v[0]; i_v_y <= p.v[1]; i_v_z <= p.v[2];
        i_w_x <= p.w[0]; i_w_y <= p.w[1]; i_w_z <= p.w[2];
        i_blend <= p.blend;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_units.push_back(predict_nlerp(p));
    endtask

    function automatic t_vec_pair make_pair(int vx, int vy, int vz, int wx, int wy, int wz,
                                            int bl);
        t_vec_pair p;
        p.v[0] = nlerp_pkg::W_COMP'(vx);
        p.v[1] = nlerp_pkg::W_COMP'(vy);
        p.v[2] = nlerp_pkg::W_COMP'(vz);
        p.w[0] = nlerp_pkg::W_COMP'(wx);
        p.w[1] = nlerp_pkg::W_COMP'(wy);
        p.w[2] = nlerp_pkg::W_COMP'(wz);
        p.blend = nlerp_pkg::W_BLEND'(bl);
        return p;
    endfunction

    function automatic logic signed [nlerp_pkg::W_COMP-1:0] rand_comp(bit tiny);
        if (tiny) return nlerp_pkg::W_COMP'($urandom_range(0, 16) - 8);
        return nlerp_pkg::W_COMP'($urandom);
    endfunction

    function automatic t_vec_pair rand_pair();
        t_vec_pair p;
        int kind = $urandom_range(0, 19);
        bit tiny = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < 3; i++) begin
            p.v[i] = rand_comp(tiny);
            p.w[i] = rand_comp(tiny);
        end
        case ($urandom_range(0, 9))
            0: p.blend = 17'd0;
            1: p.blend = nlerp_pkg::ONE_Q16;
            2: p.blend = nlerp_pkg::W_BLEND'($urandom_range(65537, 131071));
            default: p.blend = nlerp_pkg::W_BLEND'($urandom_range(0, 65536));
        endcase
        // opposite vectors at half weight, zero vectors, identical vectors
        if (kind == 0) begin
            foreach (p.w[i]) p.w[i] = -p.v[i];
            p.blend = 17'd32768;
        end else if (kind == 1) begin
            foreach (p.v[i]) p.v[i] = '0;
        end else if (kind == 2) begin
            foreach (p.w[i]) p.w[i] = '0;
        end else if (kind == 3) begin
            foreach (p.w[i]) p.w[i] = p.v[i];
        end
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_unit_vec exp_u;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected result u=(%0d,%0d,%0d) deg=%0b", $time,
                         o_u_x, o_u_y, o_u_z, o_degenerate);
                error_count++;
            end else begin
                exp_u = expected_units.pop_front();
                if (o_u_x !== exp_u.u[0] || o_u_y !== exp_u.u[1] ||
                    o_u_z !== exp_u.u[2] || o_degenerate !== exp_u.deg) begin
                    $display("%0t: mismatch expected u=(%0d,%0d,%0d) deg=%0b actual u=(%0d,%0d,%0d) deg=%0b",
                             $time, exp_u.u[0], exp_u.u[1], exp_u.u[2], exp_u.deg,
                             o_u_x, o_u_y, o_u_z, o_degenerate);
                    error_count++;
                end
            end
        end
    end

    // receiver stall: random wait after each result, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            result_wait = idle_enable ? $urandom_range(0, 5) : 0;
            i_stall <= (result_wait > 0);
        end else if (result_wait > 1) begin
            result_wait--;
            i_stall <= 1'b1;
        end else begin
            result_wait = 0;
            i_stall <= 1'b0;
        end
    end

    // run time limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_extremes();
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767, 65536));
        send_pair(make_pair(-32768, 0, 0, 0, 32767, 0, 32768));
        send_pair(make_pair(32767, -32768, 1, -1, 1, -32768, 1));
        send_pair(make_pair(1, 0, 0, 0, 0, 1, 65535));
        send_pair(make_pair(0, -1, 0, 0, 0, -1, 21845));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 40000));
    endtask

    task automatic test_degenerate();
        send_pair(make_pair(0, 0, 0, 5, 6, 7, 32768));
        send_pair(make_pair(5, 6, 7, 0, 0, 0, 32768));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(100, -200, 300, -100, 200, -300, 32768));
        send_pair(make_pair(-32768, -32768, -32768, 32767, 32767, 32767, 32768));
        send_pair(make_pair(1, 0, 0, -1, 0, 0, 32768));
    endtask

    task automatic test_blend_saturation();
        send_pair(make_pair(3, 4, 0, 0, 4, 3, 65537));
        send_pair(make_pair(3, 4, 0, 0, 4, 3, 131071));
        send_pair(make_pair(1, 0, 0, -1, 0, 0, 100000));
        send_pair(make_pair(-7, 2, 9, 8, -3, 1, 98304));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) begin
            idle_enable = ((n / 100) % 3 != 2);
            send_pair(rand_pair());
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_backpressure();
        long_hold_left = LONG_HOLD;
        idle_enable = 1'b0;
        for (int n = 0; n < 200; n++) send_pair(rand_pair());
        idle_enable = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_degenerate();
        test_blend_saturation();
        test_random(600);
        test_backpressure();
        test_random(530);
        i_valid <= 1'b0;
        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- normalized_vector_lerp.f -----
+incdir+hdl
hdl/nlerp_pkg.sv
hdl/nlerp_sqrt.sv
hdl/nlerp_div.sv
hdl/normalized_vector_lerp.sv
tb/tb_top.sv
